@@ design/sle_pkg.sv @@
// sle_pkg: shared types and constants for the sequential list engine
// request and status codes, cell control struct
// no dependencies
`timescale 1ns / 1ps

package sle_pkg;

	localparam int MAX_ENTRIES = 16;
	localparam int IDX_W = $clog2(MAX_ENTRIES);
	localparam int CNT_W = 5;
	localparam int DATA_W = 8;
	localparam int REQ_W = 3;
	localparam int STAT_W = 3;
	localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(16);
	localparam logic [CNT_W-1:0] CAP_MAX = CNT_W'(MAX_ENTRIES);

	typedef enum logic [REQ_W-1:0] {
		REQ_APPEND = 3'd0,
		REQ_INSERT = 3'd1,
		REQ_DELETE = 3'd2,
		REQ_READ   = 3'd3,
		REQ_LOCATE = 3'd4
	} req_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK       = 3'd0,
		ST_FULL     = 3'd1,
		ST_BADPOS   = 3'd2,
		ST_EMPTY    = 3'd3,
		ST_NOTFOUND = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		CELL_HOLD   = 2'd0,
		CELL_INSERT = 2'd1,
		CELL_DELETE = 2'd2
	} cell_op_t;

	typedef struct packed {
		cell_op_t          op;
		logic [IDX_W-1:0]  idx;
		logic [DATA_W-1:0] val;
	} cell_ctrl_t;

endpackage

@@ design/sle_cell.sv @@
// sle_cell: one element slot of the list chain
// shifts up or down from its neighbors, loads the new byte, flags a match
// depends on sle_pkg
`timescale 1ns / 1ps

module sle_cell (
	input  logic                      clk,
	input  sle_pkg::cell_ctrl_t       ctrl,
	input  logic [sle_pkg::IDX_W-1:0] index,
	input  logic [sle_pkg::DATA_W-1:0] left_data,
	input  logic [sle_pkg::DATA_W-1:0] right_data,
	output logic [sle_pkg::DATA_W-1:0] data,
	output logic                      match
);
	import sle_pkg::*;

	logic [DATA_W-1:0] data_q;

	always_ff @(posedge clk) begin
		case (ctrl.op)
			CELL_INSERT: begin
				if (index == ctrl.idx) begin
					data_q <= ctrl.val;
				end else if (index > ctrl.idx) begin
					data_q <= left_data;
				end
			end
			CELL_DELETE: begin
				if (index >= ctrl.idx) begin
					data_q <= right_data;
				end
			end
			default: begin
			end
		endcase
	end

	assign data = data_q;
	assign match = (data_q == ctrl.val);

endmodule

@@ design/sequential_list_engine.sv @@
// sequential_list_engine: ordered byte list held in a chain of element cells
// depends on sle_pkg and sle_cell
//
// usage:
// - request channel: start with req_type, position and value; a transfer
//   happens at a rising edge with start high and busy low. busy stays low,
//   so a request can be issued every cycle.
// - result channel: done is high for exactly one cycle, in the cycle after the
//   request transfer, with status, read_value, found_position, list_length.
//   the receiver cannot stall; results are never held back.
// - throughput 1 request per cycle: every cell shifts or loads and compares in
//   parallel in the transfer cycle, the read mux and last-match encoder settle
//   in the same cycle.
// - capacity register: cfg_data is written when cfg_valid and cfg_ready are
//   high; cfg_ready is always high. the value in force is the smaller of
//   the register and the built depth.
// - reset: list length zero, capacity 16, no result pending; element
//   contents are not cleared and are only read below the list length.
`timescale 1ns / 1ps

module sequential_list_engine (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [sle_pkg::REQ_W-1:0]   req_type,
	input  logic [sle_pkg::CNT_W-1:0]   position,
	input  logic [sle_pkg::DATA_W-1:0]  value,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [sle_pkg::CNT_W-1:0]   cfg_data,
	output logic                        done,
	output logic [sle_pkg::STAT_W-1:0]  status,
	output logic [sle_pkg::DATA_W-1:0]  read_value,
	output logic [sle_pkg::CNT_W-1:0]   found_position,
	output logic [sle_pkg::CNT_W-1:0]   list_length
);
	import sle_pkg::*;

	logic [CNT_W-1:0]  cap_q;
	logic [CNT_W-1:0]  count_q;
	logic              done_q;
	status_t           status_q;
	logic [DATA_W-1:0] read_q;
	logic [CNT_W-1:0]  found_q;

	logic [DATA_W-1:0] cell_data [MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0] cell_match;
	cell_ctrl_t        ctrl;
	logic              acc;

	logic [CNT_W-1:0]  cap_live;
	logic [CNT_W-1:0]  pos_m1;
	logic [IDX_W-1:0]  pos_idx;
	logic              full;
	logic              hit;
	logic [IDX_W-1:0]  hit_idx;
	status_t           status_nxt;
	logic [DATA_W-1:0] read_nxt;
	logic [CNT_W-1:0]  found_nxt;
	logic [CNT_W-1:0]  count_nxt;

	assign busy = 1'b0;
	assign cfg_ready = 1'b1;
	assign acc = start && !busy;

	assign cap_live = (cap_q > CAP_MAX) ? CAP_MAX : cap_q;
	assign pos_m1 = position - CNT_W'(1);
	assign pos_idx = pos_m1[IDX_W-1:0];
	assign full = (count_q >= cap_live);

	// last valid matching cell
	always_comb begin
		hit = 1'b0;
		hit_idx = '0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			if (cell_match[i] && (CNT_W'(i) < count_q)) begin
				hit = 1'b1;
				hit_idx = IDX_W'(i);
			end
		end
	end

	always_comb begin
		status_nxt = ST_OK;
		read_nxt = '0;
		found_nxt = '0;
		count_nxt = count_q;
		ctrl.op = CELL_HOLD;
		ctrl.idx = pos_idx;
		ctrl.val = value;
		unique case (req_type)
			REQ_APPEND: begin
				if (full) begin
					status_nxt = ST_FULL;
				end else begin
					ctrl.op = CELL_INSERT;
					ctrl.idx = count_q[IDX_W-1:0];
					count_nxt = count_q + CNT_W'(1);
				end
			end
			REQ_INSERT: begin
				if (full) begin
					status_nxt = ST_FULL;
				end else if (position == '0 || position > count_q + CNT_W'(1)) begin
					status_nxt = ST_BADPOS;
				end else begin
					ctrl.op = CELL_INSERT;
					count_nxt = count_q + CNT_W'(1);
				end
			end
			REQ_DELETE: begin
				if (position == '0 || position > count_q) begin
					status_nxt = ST_BADPOS;
				end else begin
					ctrl.op = CELL_DELETE;
					count_nxt = count_q - CNT_W'(1);
				end
			end
			REQ_READ: begin
				if (count_q == '0) begin
					status_nxt = ST_EMPTY;
				end else if (position == '0 || position > count_q) begin
					status_nxt = ST_BADPOS;
				end else begin
					read_nxt = cell_data[pos_idx];
				end
			end
			REQ_LOCATE: begin
				if (count_q == '0) begin
					status_nxt = ST_EMPTY;
				end else if (!hit) begin
					status_nxt = ST_NOTFOUND;
				end else begin
					found_nxt = {1'b0, hit_idx} + CNT_W'(1);
				end
			end
			default: begin
			end
		endcase
		if (!acc) begin
			ctrl.op = CELL_HOLD;
			count_nxt = count_q;
		end
	end

	for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
		logic [DATA_W-1:0] left_d;
		logic [DATA_W-1:0] right_d;
		if (g == 0) begin : g_first
			assign left_d = '0;
		end else begin : g_mid_l
			assign left_d = cell_data[g-1];
		end
		if (g == MAX_ENTRIES - 1) begin : g_last
			assign right_d = '0;
		end else begin : g_mid_r
			assign right_d = cell_data[g+1];
		end
		sle_cell u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.index      (IDX_W'(g)),
			.left_data  (left_d),
			.right_data (right_d),
			.data       (cell_data[g]),
			.match      (cell_match[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
			count_q <= '0;
			done_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				cap_q <= cfg_data;
			end
			count_q <= count_nxt;
			done_q <= acc;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			status_q <= status_nxt;
			read_q <= read_nxt;
			found_q <= found_nxt;
		end
	end

	assign done = done_q;
	assign status = status_q;
	assign read_value = read_q;
	assign found_position = found_q;
	assign list_length = count_q;

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> done)
		else $error("done missing after request transfer");

	a_no_spurious_done: assert property (@(posedge clk) disable iff (!arst_n)
		!acc |=> !done)
		else $error("done without request transfer");

	a_err_keeps_len: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != ST_OK |-> list_length == $past(count_q))
		else $error("failed request changed list length");

	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done && found_position != '0 |-> status == ST_OK && found_position <= list_length)
		else $error("found position with bad status or beyond length");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_MAX)
		else $error("list length beyond depth");

endmodule

@@ bench/sequential_list_engine_tb.sv @@
// sequential_list_engine_tb: self-checking bench for the sequential list engine
// keeps a shadow copy of the list, predicts every result and compares it field by field
// depends on sle_pkg and the sequential_list_engine rtl
`timescale 1ns / 1ps

module sequential_list_engine_tb;
	import sle_pkg::*;

	localparam int CLK_PERIOD = 10;
	localparam int RESET_CYCLES = 10;
	localparam int STALL_LIMIT = 2000;
	localparam int TAIL_CYCLES = 4;
	localparam int PHASES = 11;
	localparam int PHASE_ITEMS = 100;
	localparam int REQ_LAST = (1 << REQ_W) - 1;
	localparam int CFG_LAST = (1 << CNT_W) - 1;

	typedef struct {
		status_t           st;
		logic [DATA_W-1:0] rd;
		logic [CNT_W-1:0]  found;
		logic [CNT_W-1:0]  len;
	} list_result_t;

	class list_shadow;
		logic [DATA_W-1:0] cells [MAX_ENTRIES];
		int length;
		int capacity;
		int errors;
		list_result_t awaited_results [$];

		function new();
			length = 0;
			capacity = int'(CAP_RESET);
			errors = 0;
		endfunction

		function void set_capacity(logic [CNT_W-1:0] v);
			capacity = int'(v);
		endfunction

		function void note_request(logic [REQ_W-1:0] req, logic [CNT_W-1:0] pos,
				logic [DATA_W-1:0] val);
			list_result_t r;
			int limit;
			int p;
			int i;
			r.st = ST_OK;
			r.rd = '0;
			r.found = '0;
			limit = (capacity > MAX_ENTRIES) ? MAX_ENTRIES : capacity;
			p = int'(pos);
			case (req)
				REQ_APPEND: begin
					if (length >= limit) begin
						r.st = ST_FULL;
					end else begin
						cells[length] = val;
						length++;
					end
				end
				REQ_INSERT: begin
					if (length >= limit) begin
						r.st = ST_FULL;
					end else if (p < 1 || p > length + 1 || length >= MAX_ENTRIES) begin
						r.st = ST_BADPOS;
					end else begin
						for (i = length; i > p - 1; i--)
							cells[i] = cells[i-1];
						cells[p-1] = val;
						length++;
					end
				end
				REQ_DELETE: begin
					if (p < 1 || p > length) begin
						r.st = ST_BADPOS;
					end else begin
						for (i = p - 1; i + 1 < length; i++)
							cells[i] = cells[i+1];
						length--;
					end
				end
				REQ_READ: begin
					if (length == 0)
						r.st = ST_EMPTY;
					else if (p < 1 || p > length)
						r.st = ST_BADPOS;
					else
						r.rd = cells[p-1];
				end
				REQ_LOCATE: begin
					if (length == 0) begin
						r.st = ST_EMPTY;
					end else begin
						for (i = 0; i < length; i++)
							if (cells[i] == val)
								r.found = CNT_W'(i + 1);
						if (r.found == 0)
							r.st = ST_NOTFOUND;
					end
				end
				default: begin
				end
			endcase
			r.len = CNT_W'(length);
			awaited_results.push_back(r);
		endfunction

		function void check_result(logic [STAT_W-1:0] st, logic [DATA_W-1:0] rd,
				logic [CNT_W-1:0] found, logic [CNT_W-1:0] len);
			list_result_t e;
			if (awaited_results.size() == 0) begin
				$error("result transfer with no request outstanding");
				errors++;
				return;
			end
			e = awaited_results.pop_front();
			if (st !== e.st) begin
				$error("status: expected %0d, actual %0d", e.st, st);
				errors++;
			end
			if (rd !== e.rd) begin
				$error("read_value: expected %0d, actual %0d", e.rd, rd);
				errors++;
			end
			if (found !== e.found) begin
				$error("found_position: expected %0d, actual %0d", e.found, found);
				errors++;
			end
			if (len !== e.len) begin
				$error("list_length: expected %0d, actual %0d", e.len, len);
				errors++;
			end
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic [REQ_W-1:0]    req_type;
	logic [CNT_W-1:0]    position;
	logic [DATA_W-1:0]   value;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [CNT_W-1:0]    cfg_data;
	logic                done;
	logic [STAT_W-1:0]   status;
	logic [DATA_W-1:0]   read_value;
	logic [CNT_W-1:0]    found_position;
	logic [CNT_W-1:0]    list_length;

	list_shadow shadow;
	int idle_pct;
	int stall_cycles;

	sequential_list_engine u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.req_type       (req_type),
		.position       (position),
		.value          (value),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.done           (done),
		.status         (status),
		.read_value     (read_value),
		.found_position (found_position),
		.list_length    (list_length)
	);

	initial clk = 1'b0;
	always #(CLK_PERIOD / 2) clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && done)
			shadow.check_result(status, read_value, found_position, list_length);
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	task automatic send_request(logic [REQ_W-1:0] req, logic [CNT_W-1:0] pos,
			logic [DATA_W-1:0] val);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		req_type <= req;
		position <= pos;
		value <= val;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		shadow.note_request(req, pos, val);
	endtask

	task automatic drain_results();
		start <= 1'b0;
		while (shadow.awaited_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_capacity(logic [CNT_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		shadow.set_capacity(v);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [REQ_W-1:0] pick_request(bit grow);
		int r;
		r = $urandom_range(99);
		if (grow) begin
			if (r < 40) return REQ_APPEND;
			if (r < 65) return REQ_INSERT;
			if (r < 73) return REQ_DELETE;
			if (r < 84) return REQ_READ;
			if (r < 96) return REQ_LOCATE;
		end else begin
			if (r < 10) return REQ_APPEND;
			if (r < 20) return REQ_INSERT;
			if (r < 55) return REQ_DELETE;
			if (r < 75) return REQ_READ;
			if (r < 95) return REQ_LOCATE;
		end
		return REQ_W'($urandom_range(int'(REQ_LOCATE) + 1, REQ_LAST));
	endfunction

	function automatic logic [CNT_W-1:0] pick_position();
		if ($urandom_range(9) < 8)
			return CNT_W'($urandom_range(1, shadow.length + 1));
		return CNT_W'($urandom_range(0, CFG_LAST));
	endfunction

	function automatic logic [DATA_W-1:0] pick_value();
		// a small pool makes locate hits and repeated matches common
		if ($urandom_range(1))
			return DATA_W'($urandom_range(0, 7));
		return DATA_W'($urandom);
	endfunction

	initial begin
		int caps [PHASES];
		bit grow [PHASES];
		shadow = new();
		idle_pct = 11;
		arst_n <= 1'b0;
		start <= 1'b0;
		req_type <= REQ_APPEND;
		position <= '0;
		value <= '0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		caps = '{int'(CAP_RESET), CFG_LAST, 3, 0, 1, int'(CAP_MAX), 2,
			$urandom_range(0, CFG_LAST), $urandom_range(0, CFG_LAST),
			$urandom_range(0, CFG_LAST), int'(CAP_MAX)};
		grow = '{1, 1, 0, 1, 0, 1, 1, 0, 1, 0, 1};
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list cases
		send_request(REQ_READ, 1, 8'h00);
		send_request(REQ_LOCATE, 1, 8'h00);
		send_request(REQ_DELETE, 1, 8'h00);
		// insert position edges, then build ff aa 00 aa 55
		send_request(REQ_INSERT, 0, 8'h01);
		send_request(REQ_INSERT, 2, 8'h01);
		send_request(REQ_INSERT, 1, 8'hFF);
		send_request(REQ_APPEND, 31, 8'h00);
		send_request(REQ_APPEND, 0, 8'hAA);
		send_request(REQ_INSERT, 4, 8'h55);
		send_request(REQ_INSERT, 2, 8'hAA);
		// read bounds
		send_request(REQ_READ, 0, 8'h00);
		send_request(REQ_READ, 31, 8'h00);
		send_request(REQ_READ, 6, 8'h00);
		send_request(REQ_READ, 1, 8'hFF);
		send_request(REQ_READ, 5, 8'h00);
		// last match and miss
		send_request(REQ_LOCATE, 0, 8'hAA);
		send_request(REQ_LOCATE, 31, 8'h12);
		// delete last, first, out of range
		send_request(REQ_DELETE, 5, 8'h00);
		send_request(REQ_DELETE, 1, 8'h00);
		send_request(REQ_DELETE, 31, 8'hFF);
		send_request(REQ_DELETE, 0, 8'h00);
		// unused request codes
		send_request(REQ_W'(int'(REQ_LOCATE) + 1), 31, 8'hFF);
		send_request(REQ_W'(REQ_LAST), 0, 8'h00);

		for (int ph = 0; ph < PHASES; ph++) begin
			drain_results();
			write_capacity(CNT_W'(caps[ph]));
			idle_pct = (ph == 5) ? 0 : 11;
			for (int n = 0; n < PHASE_ITEMS; n++)
				send_request(pick_request(grow[ph]), pick_position(), pick_value());
		end

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (shadow.errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
